>>> rtl/wmf_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, codes and helpers of the window minimum filter.
package wmf_pkg;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int WIN_W      = 4;
    localparam int HALF_W     = 3;
    localparam int ROW_W      = 13;
    localparam int LAG_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 3'd3;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST   = 11'd640;
    localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST  = 12'd480;
    localparam logic [WIN_W-1:0] WINDOW_HEIGHT_RST = 4'd3;
    localparam logic [WIN_W-1:0] WINDOW_WIDTH_RST  = 4'd3;

    typedef struct packed {
        logic             inc;
        logic [PIX_W-1:0] value;
    } t_pix_sel;

    typedef struct packed {
        logic acc;
        logic wr_en;
    } t_store_ctl;

    typedef struct packed {
        logic shift;
        logic odd;
    } t_col_ctl;

    function automatic logic [PIX_W-1:0] min_pix(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

>>> rtl/wmf_line_store.sv
`timescale 1ns / 1ps
// Banked line store with registered reads and the vertical minimum over one column.
module wmf_line_store #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HALF  = 7
) (
    input  logic                                   i_clk,
    input  wmf_pkg::t_store_ctl                    i_ctl,
    input  logic [$clog2(2*MAX_HALF+2)-1:0]        i_wr_bank,
    input  logic [$clog2(MAX_WIDTH)-1:0]           i_addr,
    input  logic [wmf_pkg::PIX_W-1:0]              i_wr_data,
    input  wmf_pkg::t_pix_sel                      i_cur,
    input  logic [2*MAX_HALF+1:0]                  i_vmask,
    output logic [wmf_pkg::PIX_W-1:0]              o_cmin
);

    localparam int ROWS   = 2 * MAX_HALF + 2;
    localparam int BANK_W = $clog2(ROWS);
    localparam int LOGV   = $clog2(ROWS + 1);
    localparam int VN     = 2 ** LOGV;

    logic [wmf_pkg::PIX_W-1:0] r_rd [ROWS];

    for (genvar b = 0; b < ROWS; b++) begin : g_bank
        logic [wmf_pkg::PIX_W-1:0] r_mem [MAX_WIDTH];

        always_ff @(posedge i_clk) begin
            if (i_ctl.acc) begin
                if (i_ctl.wr_en && (i_wr_bank == BANK_W'(b))) begin
                    r_mem[i_addr] <= i_wr_data;
                end
                r_rd[b] <= r_mem[i_addr];
            end
        end
    end

    always_comb begin
        logic [wmf_pkg::PIX_W-1:0] t [VN];
        for (int i = 0; i < VN; i++) begin
            t[i] = wmf_pkg::PIX_MAX;
        end
        for (int b = 0; b < ROWS; b++) begin
            if (i_vmask[b]) begin
                t[b] = r_rd[b];
            end
        end
        if (i_cur.inc) begin
            t[ROWS] = i_cur.value;
        end
        for (int lv = 0; lv < LOGV; lv++) begin
            for (int i = 0; i < (VN >> (lv + 1)); i++) begin
                t[i] = wmf_pkg::min_pix(t[2*i], t[2*i+1]);
            end
        end
        o_cmin = t[0];
    end

endmodule

>>> rtl/wmf_col_window.sv
`timescale 1ns / 1ps
// Shift line of column minima and the masked horizontal minimum across it.
module wmf_col_window #(
    parameter int MAX_HALF = 7
) (
    input  logic                      i_clk,
    input  wmf_pkg::t_col_ctl         i_ctl,
    input  logic [wmf_pkg::PIX_W-1:0] i_cmin,
    input  logic [2*MAX_HALF:0]       i_hmask,
    output logic [wmf_pkg::PIX_W-1:0] o_min
);

    localparam int LANES = 2 * MAX_HALF + 1;
    localparam int LOGH  = $clog2(LANES);
    localparam int HN    = 2 ** LOGH;

    logic [wmf_pkg::PIX_W-1:0] r_line [LANES-1];

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_line[0] <= i_cmin;
            for (int k = 1; k < LANES - 1; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    always_comb begin
        logic [wmf_pkg::PIX_W-1:0] t [HN];
        for (int i = 0; i < HN; i++) begin
            t[i] = wmf_pkg::PIX_MAX;
        end
        if (i_hmask[0]) begin
            t[0] = i_cmin;
        end
        for (int a = 1; a < LANES; a++) begin
            if (i_hmask[a]) begin
                t[a] = r_line[a-1];
            end
        end
        for (int lv = 0; lv < LOGH; lv++) begin
            for (int i = 0; i < (HN >> (lv + 1)); i++) begin
                t[i] = wmf_pkg::min_pix(t[2*i], t[2*i+1]);
            end
        end
        o_min = i_ctl.odd ? t[0] : '0;
    end

endmodule

>>> rtl/window_min_filter_top.sv
`timescale 1ns / 1ps
// Top level of the rectangular grayscale minimum filter over a raster pixel stream.
//
//   Channel  Handshake                  Payload
//   input    i_in_valid / o_in_stall    i_action, i_pixel
//   output   o_out_valid / i_out_stall  o_min_value, o_last_of_frame
//   config   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One input transaction is taken every cycle while o_in_stall is low; the rate is set by
// one write and one read per line store bank per cycle. A result is registered in stage one,
// stage two and the output register in turn after the input transaction that completes its
// window. Reset is synchronous and restores the register defaults, the frame position and
// the pipeline; the line store needs no clearing. o_in_stall rises only when the output
// holds an untaken result and both stages behind it are full.
module window_min_filter_top #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HALF  = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_action,
    input  logic [wmf_pkg::PIX_W-1:0]          i_pixel,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [wmf_pkg::PIX_W-1:0]          o_min_value,
    output logic                               o_last_of_frame,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [wmf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wmf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int ROWS   = 2 * MAX_HALF + 2;
    localparam int LANES  = 2 * MAX_HALF + 1;
    localparam int BANK_W = $clog2(ROWS);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CW     = ((COL_W > wmf_pkg::FW_W) ? COL_W : wmf_pkg::FW_W) + 1;

    logic [wmf_pkg::FW_W-1:0]  r_frame_width;
    logic [wmf_pkg::FH_W-1:0]  r_frame_height;
    logic [wmf_pkg::WIN_W-1:0] r_window_height;
    logic [wmf_pkg::WIN_W-1:0] r_window_width;

    logic [COL_W-1:0]          r_ic, n_ic;
    logic [wmf_pkg::ROW_W-1:0] r_ir, n_ir;
    logic [BANK_W-1:0]         r_bank, n_bank;
    logic [wmf_pkg::LAG_W-1:0] r_lag, n_lag;
    logic [COL_W-1:0]          r_oc, n_oc;
    logic [wmf_pkg::FH_W-1:0]  r_or, n_or;

    logic                      r_v1;
    wmf_pkg::t_pix_sel         r_cur;
    logic [ROWS-1:0]           r_vmask;
    logic [LANES-1:0]          r_hmask1;
    logic                      r_prod1;
    logic                      r_last1;
    logic                      r_odd1;

    logic                      r_v2;
    logic [wmf_pkg::PIX_W-1:0] r_cmin2;
    logic [LANES-1:0]          r_hmask2;
    logic                      r_prod2;
    logic                      r_last2;
    logic                      r_odd2;

    logic                      r_out_valid;
    logic [wmf_pkg::PIX_W-1:0] r_min;
    logic                      r_last;

    logic                      en_out, en2, en1, acc;
    logic                      cfg_restart;
    logic [wmf_pkg::FW_W-1:0]  w;
    logic [wmf_pkg::FH_W-1:0]  h;
    logic [wmf_pkg::HALF_W-1:0] hh, hw;
    logic [wmf_pkg::LAG_W-1:0] delay;
    logic                      odd;
    logic                      in_img;
    logic                      s0_prod, s0_last;
    logic [ROWS-1:0]           vmask;
    logic [LANES-1:0]          hmask;
    logic [wmf_pkg::PIX_W-1:0] wr_data;
    logic [wmf_pkg::PIX_W-1:0] cmin;
    logic [wmf_pkg::PIX_W-1:0] hmin;
    wmf_pkg::t_store_ctl       store_ctl;
    wmf_pkg::t_col_ctl         col_ctl;

    assign o_cfg_ready = 1'b1;

    assign en_out     = !r_out_valid || !i_out_stall;
    assign en2        = !r_v2 || en_out;
    assign en1        = !r_v1 || en2;
    assign acc        = i_in_valid && en1;
    assign o_in_stall = !en1;

    always_comb begin
        case (i_cfg_index)
            wmf_pkg::CFG_FRAME_WIDTH:   cfg_restart = i_cfg_valid;
            wmf_pkg::CFG_FRAME_HEIGHT:  cfg_restart = i_cfg_valid;
            wmf_pkg::CFG_WINDOW_HEIGHT: cfg_restart = i_cfg_valid;
            wmf_pkg::CFG_WINDOW_WIDTH:  cfg_restart = i_cfg_valid;
            default:                    cfg_restart = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= wmf_pkg::FRAME_WIDTH_RST;
            r_frame_height  <= wmf_pkg::FRAME_HEIGHT_RST;
            r_window_height <= wmf_pkg::WINDOW_HEIGHT_RST;
            r_window_width  <= wmf_pkg::WINDOW_WIDTH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wmf_pkg::CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data[wmf_pkg::FW_W-1:0];
                wmf_pkg::CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data[wmf_pkg::FH_W-1:0];
                wmf_pkg::CFG_WINDOW_HEIGHT: r_window_height <= i_cfg_data[wmf_pkg::WIN_W-1:0];
                wmf_pkg::CFG_WINDOW_WIDTH:  r_window_width  <= i_cfg_data[wmf_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame and window geometry.
    always_comb begin
        if (r_frame_width == '0) begin
            w = wmf_pkg::FW_W'(1);
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            w = wmf_pkg::FW_W'(MAX_WIDTH);
        end else begin
            w = r_frame_width;
        end
        h = (r_frame_height == '0) ? wmf_pkg::FH_W'(1) : r_frame_height;
        if (int'(r_window_height[wmf_pkg::WIN_W-1:1]) > MAX_HALF) begin
            hh = wmf_pkg::HALF_W'(MAX_HALF);
        end else begin
            hh = r_window_height[wmf_pkg::WIN_W-1:1];
        end
        if (int'(r_window_width[wmf_pkg::WIN_W-1:1]) > MAX_HALF) begin
            hw = wmf_pkg::HALF_W'(MAX_HALF);
        end else begin
            hw = r_window_width[wmf_pkg::WIN_W-1:1];
        end
        delay = wmf_pkg::LAG_W'(hh) * wmf_pkg::LAG_W'(w) + wmf_pkg::LAG_W'(hw);
        odd   = r_window_height[0] || r_window_width[0];
    end

    // Per-transaction decisions taken from the frame position.
    always_comb begin
        logic [BANK_W-1:0] vb;
        vb      = '0;
        in_img  = r_ir < wmf_pkg::ROW_W'(h);
        wr_data = (i_action == wmf_pkg::ACT_DRAIN) ? wmf_pkg::PIX_MAX : i_pixel;
        s0_prod = r_lag >= delay;
        s0_last = s0_prod && (r_or == h - 1'b1) && (CW'(r_oc) == CW'(w) - CW'(1));
        vmask   = '0;
        for (int d = 1; d <= 2 * MAX_HALF; d++) begin
            if (d <= 2 * int'(hh) && int'(r_ir) >= d && int'(r_ir) < int'(h) + d) begin
                if (int'(r_bank) >= d) begin
                    vb = BANK_W'(int'(r_bank) - d);
                end else begin
                    vb = BANK_W'(int'(r_bank) + ROWS - d);
                end
                vmask[vb] = 1'b1;
            end
        end
        for (int a = 0; a < LANES; a++) begin
            hmask[a] = (a <= 2 * int'(hw)) && (int'(r_oc) + int'(hw) >= a)
                       && (int'(r_oc) + int'(hw) < int'(w) + a);
        end
    end

    always_comb begin
        n_ic   = r_ic;
        n_ir   = r_ir;
        n_bank = r_bank;
        n_lag  = r_lag;
        n_oc   = r_oc;
        n_or   = r_or;
        if (cfg_restart || (acc && s0_last)) begin
            n_ic   = '0;
            n_ir   = '0;
            n_bank = '0;
            n_lag  = '0;
            n_oc   = '0;
            n_or   = '0;
        end else if (acc) begin
            if (s0_prod) begin
                if (CW'(r_oc) + CW'(1) >= CW'(w)) begin
                    n_oc = '0;
                    n_or = r_or + 1'b1;
                end else begin
                    n_oc = r_oc + 1'b1;
                end
            end
            if (CW'(r_ic) + CW'(1) >= CW'(w)) begin
                n_ic   = '0;
                n_ir   = r_ir + 1'b1;
                n_bank = (r_bank == BANK_W'(ROWS - 1)) ? '0 : r_bank + 1'b1;
            end else begin
                n_ic = r_ic + 1'b1;
            end
            if (r_lag < delay) begin
                n_lag = r_lag + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic        <= '0;
            r_ir        <= '0;
            r_bank      <= '0;
            r_lag       <= '0;
            r_oc        <= '0;
            r_or        <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ic   <= n_ic;
            r_ir   <= n_ir;
            r_bank <= n_bank;
            r_lag  <= n_lag;
            r_oc   <= n_oc;
            r_or   <= n_or;
            if (en1) begin
                r_v1 <= acc;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en_out) begin
                r_out_valid <= r_v2 && r_prod2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cur.inc   <= in_img;
            r_cur.value <= wr_data;
            r_vmask     <= vmask;
            r_hmask1    <= hmask;
            r_prod1     <= s0_prod;
            r_last1     <= s0_last;
            r_odd1      <= odd;
        end
        if (en2 && r_v1) begin
            r_cmin2  <= cmin;
            r_hmask2 <= r_hmask1;
            r_prod2  <= r_prod1;
            r_last2  <= r_last1;
            r_odd2   <= r_odd1;
        end
        if (en_out && r_v2 && r_prod2) begin
            r_min  <= hmin;
            r_last <= r_last2;
        end
    end

    assign store_ctl.acc   = acc;
    assign store_ctl.wr_en = in_img;

    wmf_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HALF  (MAX_HALF)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_ctl     (store_ctl),
        .i_wr_bank (r_bank),
        .i_addr    (r_ic),
        .i_wr_data (wr_data),
        .i_cur     (r_cur),
        .i_vmask   (r_vmask),
        .o_cmin    (cmin)
    );

    assign col_ctl.shift = r_v2 && en_out;
    assign col_ctl.odd   = r_odd2;

    wmf_col_window #(
        .MAX_HALF (MAX_HALF)
    ) u_col_window (
        .i_clk   (i_clk),
        .i_ctl   (col_ctl),
        .i_cmin  (r_cmin2),
        .i_hmask (r_hmask2),
        .o_min   (hmin)
    );

    assign o_out_valid     = r_out_valid;
    assign o_min_value     = r_min;
    assign o_last_of_frame = r_last;

endmodule

>>> rtl/wmf_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the window minimum filter and their bind to the top level.
module wmf_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [wmf_pkg::PIX_W-1:0] o_min_value,
    input logic                      o_last_of_frame
);

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_min_value)
                                       && $stable(o_last_of_frame))
        else $error("Stalled output transaction changed or vanished.");

    // With the output register empty, the whole pipeline can advance.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("Input stalled while the output register is empty.");

    // Reset leaves no result on the output.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid right after reset.");

    // An input transaction can only be refused when a result is waiting downstream.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |-> o_out_valid && i_out_stall)
        else $error("Input stalled without a stalled output transaction.");

endmodule

bind window_min_filter_top wmf_checker u_wmf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_min_value     (o_min_value),
    .o_last_of_frame (o_last_of_frame)
);
